// File: hdl/pidis_pkg.sv
// ----------------------------------------------------------------------------
// pidis_pkg
// Shared types and constants of the PID core with integral separation:
// register indexes, field widths and pipeline stage payloads.
// ----------------------------------------------------------------------------
package pidis_pkg;

   localparam int ErrW   = 16;
   localparam int GainW  = 16;
   localparam int ThrW   = 15;
   localparam int LimW   = 31;
   localparam int DataW  = 32;
   localparam int IdxW   = 3;
   localparam int PdW    = 33;                 // kp*e + kd*d
   localparam int PiW    = GainW + DataW;      // ki*integral
   localparam int TotW   = PiW + 1;

   typedef enum logic [IdxW-1:0] {
      REG_GAIN_PROP  = 3'd0,
      REG_GAIN_INTEG = 3'd1,
      REG_GAIN_DERIV = 3'd2,
      REG_SEP_THR    = 3'd3,
      REG_WINDUP_LIM = 3'd4,
      REG_CLAMP_EN   = 3'd5,
      REG_OUT_UPPER  = 3'd6,
      REG_OUT_LOWER  = 3'd7
   } reg_index_type;

   // Payload between the integral stage and the integral product stage.
   typedef struct packed {
      logic                    clear;
      logic                    use_integ;
      logic signed [PdW-1:0]   pd_sum;
      logic signed [DataW-1:0] integ;
   } stage1_type;

   // Payload between the integral product stage and the output stage.
   typedef struct packed {
      logic                    clear;
      logic                    use_integ;
      logic signed [PdW-1:0]   pd_sum;
      logic signed [PiW-1:0]   pi_prod;
   } stage2_type;

endpackage

// File: hdl/pid_integral_separation_core.sv
// ----------------------------------------------------------------------------
// pid_integral_separation_core
// Positional PID step with integral separation, anti-windup and optional
// output clamp. Gains are signed Q8.8.
// ----------------------------------------------------------------------------
// A word passes the input, stage 1, stage 2 and output registers in turn.
// Throughput: one word per cycle while results are taken; each stage holds its
// word only while the next is full, so input fills in behind a waiting result.
// The integral is updated in the first stage, so successive words see it.
// Reset clears the integral and the pipeline and loads the register defaults.
module pid_integral_separation_core
   import pidis_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  logic signed [ErrW-1:0]  req_error_in,
   input  logic signed [ErrW-1:0]  req_deriv_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [DataW-1:0] rsp_drive_out,
   output logic                    rsp_integ_used,
   input  logic                    csr_we,
   input  logic [IdxW-1:0]         csr_index,
   input  logic [DataW-1:0]        csr_wdata
);

   // Configuration registers.
   logic signed [GainW-1:0] kp_ff, ki_ff, kd_ff;
   logic [ThrW-1:0]         thr_ff;
   logic [LimW-1:0]         lim_ff;
   logic                    clamp_ff;
   logic signed [DataW-1:0] upper_ff, lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= '0;
         ki_ff    <= '0;
         kd_ff    <= '0;
         thr_ff   <= '1;
         lim_ff   <= '1;
         clamp_ff <= 1'b0;
         upper_ff <= {1'b0, {(DataW-1){1'b1}}};
         lower_ff <= {1'b1, {(DataW-1){1'b0}}};
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_GAIN_PROP:  kp_ff    <= csr_wdata[GainW-1:0];
            REG_GAIN_INTEG: ki_ff    <= csr_wdata[GainW-1:0];
            REG_GAIN_DERIV: kd_ff    <= csr_wdata[GainW-1:0];
            REG_SEP_THR:    thr_ff   <= csr_wdata[ThrW-1:0];
            REG_WINDUP_LIM: lim_ff   <= csr_wdata[LimW-1:0];
            REG_CLAMP_EN:   clamp_ff <= csr_wdata[0];
            REG_OUT_UPPER:  upper_ff <= csr_wdata;
            REG_OUT_LOWER:  lower_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // Pipeline valid bits and per-stage move conditions.
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic out_open, s2_open, s1_open, s0_open;
   logic s0_move;

   assign out_open  = !out_valid_ff || rsp_ready;
   assign s2_open   = !s2_valid_ff || out_open;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign s0_open   = !s0_valid_ff || s1_open;
   assign s0_move   = s0_valid_ff && s1_open;
   assign req_ready = s0_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s0_open)  s0_valid_ff  <= req_valid;
         if (s1_open)  s1_valid_ff  <= s0_valid_ff;
         if (s2_open)  s2_valid_ff  <= s1_valid_ff;
         if (out_open) out_valid_ff <= s2_valid_ff;
      end
   end

   // Input register.
   logic                   action_ff;
   logic signed [ErrW-1:0] err_ff, der_ff;

   always_ff @(posedge clock) begin
      if (s0_open) begin
         action_ff <= req_action;
         err_ff    <= req_error_in;
         der_ff    <= req_deriv_in;
      end
   end

   // Stage 0: separation test, anti-windup, saturating accumulation and the P and D products.
   logic signed [DataW-1:0] integ_ff, integ_in;
   logic signed [ErrW:0]    err_x, thr_x;
   logic signed [DataW:0]   acc_x, lim_x, acc_sum;
   logic                    use_integ, add_err;
   logic signed [DataW-1:0] acc_sat;
   logic signed [DataW-1:0] p_prod, d_prod;
   stage1_type              s1_ff, s1_in;

   always_comb begin
      err_x     = {err_ff[ErrW-1], err_ff};
      thr_x     = {2'b00, thr_ff};
      use_integ = !((err_x > thr_x) || (err_x < -thr_x));
      acc_x     = {integ_ff[DataW-1], integ_ff};
      lim_x     = {2'b00, lim_ff};
      if (acc_x > lim_x) begin
         add_err = err_ff[ErrW-1];
      end else if (acc_x < -lim_x) begin
         add_err = !err_ff[ErrW-1] && (err_ff != '0);
      end else begin
         add_err = 1'b1;
      end
      acc_sum = acc_x + (DataW+1)'(err_ff);
      if (acc_sum[DataW] != acc_sum[DataW-1]) begin
         acc_sat = acc_sum[DataW] ? {1'b1, {(DataW-1){1'b0}}}
                                  : {1'b0, {(DataW-1){1'b1}}};
      end else begin
         acc_sat = acc_sum[DataW-1:0];
      end

      if (action_ff) begin
         integ_in = '0;
      end else if (use_integ && add_err) begin
         integ_in = acc_sat;
      end else begin
         integ_in = integ_ff;
      end

      p_prod          = DataW'(kp_ff) * DataW'(err_ff);
      d_prod          = DataW'(kd_ff) * DataW'(der_ff);
      s1_in.clear     = action_ff;
      s1_in.use_integ = use_integ && !action_ff;
      s1_in.pd_sum    = PdW'(p_prod) + PdW'(d_prod);
      s1_in.integ     = integ_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (s0_move) begin
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_open) begin
         s1_ff <= s1_in;
      end
   end

   // Stage 1: integral product, dropped when the integral is separated out.
   stage2_type s2_ff, s2_in;

   always_comb begin
      s2_in.clear     = s1_ff.clear;
      s2_in.use_integ = s1_ff.use_integ;
      s2_in.pd_sum    = s1_ff.pd_sum;
      s2_in.pi_prod   = s1_ff.use_integ ? PiW'(PiW'(ki_ff) * PiW'(s1_ff.integ)) : '0;
   end

   always_ff @(posedge clock) begin
      if (s2_open) begin
         s2_ff <= s2_in;
      end
   end

   function automatic logic signed [DataW:0] upper_limit_32();
      return {2'b00, {(DataW-1){1'b1}}};
   endfunction

   // Stage 2: sum, floor divide by 256, saturate, clamp, and force zero on a clear.
   logic signed [TotW-1:0]    total;
   logic signed [TotW-9:0]    quot;
   logic signed [DataW-1:0]   sat_val, drive_in, drive_ff;
   logic                      used_ff;

   always_comb begin
      total = TotW'(s2_ff.pi_prod) + TotW'(s2_ff.pd_sum);
      // An arithmetic shift rounds toward minus infinity.
      quot  = total[TotW-1:8];
      if (quot > (TotW-8)'(upper_limit_32())) begin
         sat_val = {1'b0, {(DataW-1){1'b1}}};
      end else if (quot < -(TotW-8)'(upper_limit_32()) - (TotW-8)'(1)) begin
         sat_val = {1'b1, {(DataW-1){1'b0}}};
      end else begin
         sat_val = quot[DataW-1:0];
      end
      drive_in = sat_val;
      if (clamp_ff) begin
         if (sat_val > upper_ff) begin
            drive_in = upper_ff;
         end else if (sat_val < lower_ff) begin
            drive_in = lower_ff;
         end
      end
      if (s2_ff.clear) begin
         drive_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_open) begin
         drive_ff <= drive_in;
         used_ff  <= s2_ff.use_integ;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_drive_out  = drive_ff;
   assign rsp_integ_used = used_ff;

endmodule

// File: verif/pid_check_pkg.sv
// ----------------------------------------------------------------------------
// pid_check_pkg
// Scoreboard for the PID core with integral separation. It keeps its own
// copy of the registers and the integral, works out the output of every
// accepted word and compares the results of the core against it in order.
// ----------------------------------------------------------------------------
package pid_check_pkg;
   import pidis_pkg::*;

   localparam longint I32Max      = 64'sd2147483647;
   localparam longint I32Min      = -64'sd2147483648;

   typedef struct packed {
      logic signed [DataW-1:0] drive;
      logic                    used;
   } step_result_type;

   class pid_scoreboard;
      logic signed [GainW-1:0] gain_p;
      logic signed [GainW-1:0] gain_i;
      logic signed [GainW-1:0] gain_d;
      logic [ThrW-1:0]         sep_thr;
      logic [LimW-1:0]         windup_lim;
      logic                    clamp_en;
      logic signed [DataW-1:0] out_hi;
      logic signed [DataW-1:0] out_lo;
      logic signed [DataW-1:0] integral;
      step_result_type         pending_outputs[$];
      int unsigned             mismatches;
      int unsigned             words_in;
      int unsigned             clears;
      int unsigned             frozen;
      int unsigned             held_back;
      int unsigned             rail_hi;
      int unsigned             rail_lo;
      int unsigned             out_sat;
      int unsigned             clamped;

      function new();
         gain_p     = '0;
         gain_i     = '0;
         gain_d     = '0;
         sep_thr    = '1;
         windup_lim = '1;
         clamp_en   = 1'b0;
         out_hi     = 32'h7FFF_FFFF;
         out_lo     = 32'h8000_0000;
         integral   = '0;
         mismatches = 0;
         words_in   = 0;
         clears     = 0;
         frozen     = 0;
         held_back  = 0;
         rail_hi    = 0;
         rail_lo    = 0;
         out_sat    = 0;
         clamped    = 0;
      endfunction

      static function longint limit32(longint x);
         if (x > I32Max) return I32Max;
         if (x < I32Min) return I32Min;
         return x;
      endfunction

      function void write_register(reg_index_type idx, logic [DataW-1:0] data);
         case (idx)
            REG_GAIN_PROP:  gain_p     = data[GainW-1:0];
            REG_GAIN_INTEG: gain_i     = data[GainW-1:0];
            REG_GAIN_DERIV: gain_d     = data[GainW-1:0];
            REG_SEP_THR:    sep_thr    = data[ThrW-1:0];
            REG_WINDUP_LIM: windup_lim = data[LimW-1:0];
            REG_CLAMP_EN:   clamp_en   = data[0];
            REG_OUT_UPPER:  out_hi     = data;
            REG_OUT_LOWER:  out_lo     = data;
            default: ;
         endcase
      endfunction

      // One controller step; the integral is updated before it is used.
      function step_result_type pid_step(logic act, logic signed [ErrW-1:0] err,
                                         logic signed [ErrW-1:0] der);
         step_result_type r;
         longint          e, d, thr, lim, acc, sum, q, kp, ki, kd, iv, hi, lo;
         bit              add;
         r = '0;
         if (act) begin
            integral = '0;
            clears++;
            return r;
         end
         e   = longint'(err);
         d   = longint'(der);
         thr = longint'(sep_thr);
         lim = longint'(windup_lim);
         kp  = longint'(gain_p);
         ki  = longint'(gain_i);
         kd  = longint'(gain_d);
         r.used = !(e > thr || e < -thr);
         if (!r.used) begin
            frozen++;
         end else begin
            acc = longint'(integral);
            if (acc > lim) add = (e < 0);
            else if (acc < -lim) add = (e > 0);
            else add = 1'b1;
            if (!add) begin
               held_back++;
            end else begin
               if (acc + e > I32Max) rail_hi++;
               else if (acc + e < I32Min) rail_lo++;
               integral = DataW'(limit32(acc + e));
            end
         end
         iv  = longint'(integral);
         sum = kp * e + kd * d;
         if (r.used) sum += ki * iv;
         // Arithmetic shift of the exact sum is a division rounded toward minus infinity.
         q = sum >>> 8;
         if (q > I32Max || q < I32Min) out_sat++;
         q = limit32(q);
         if (clamp_en) begin
            hi = longint'(out_hi);
            lo = longint'(out_lo);
            if (q > hi) begin
               q = hi;
               clamped++;
            end else if (q < lo) begin
               q = lo;
               clamped++;
            end
         end
         r.drive = DataW'(q);
         return r;
      endfunction

      function void note_word(logic act, logic signed [ErrW-1:0] err,
                              logic signed [ErrW-1:0] der);
         words_in++;
         pending_outputs.push_back(pid_step(act, err, der));
      endfunction

      function void check_word(logic signed [DataW-1:0] drive, logic used);
         step_result_type want;
         if (pending_outputs.size() == 0) begin
            mismatches++;
            $error("unexpected result word: drive_out=%0d integ_used=%0b", drive, used);
            return;
         end
         want = pending_outputs.pop_front();
         if (drive !== want.drive) begin
            mismatches++;
            $error("drive_out: expected %0d, got %0d", want.drive, drive);
         end
         if (used !== want.used) begin
            mismatches++;
            $error("integ_used: expected %0b, got %0b", want.used, used);
         end
      endfunction
   endclass

endpackage

// File: verif/tb_pid_integral_separation_core.sv
// ----------------------------------------------------------------------------
// tb_pid_integral_separation_core
// Drives control words into the PID core under random valid and ready
// gaps, reprograms the registers between phases, and checks every result
// word in order against the scoreboard, including runs into the windup limit.
// ----------------------------------------------------------------------------
module tb_pid_integral_separation_core
   import pidis_pkg::*;
   import pid_check_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 4000;
   localparam int HoldCycles    = 300;
   localparam int RandomPhases  = 6;

   typedef struct packed {
      logic                   action;
      logic signed [ErrW-1:0] err;
      logic signed [ErrW-1:0] der;
   } step_word_type;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_ready;
   logic                    req_action     = 1'b0;
   logic signed [ErrW-1:0]  req_error_in   = '0;
   logic signed [ErrW-1:0]  req_deriv_in   = '0;
   logic                    rsp_valid;
   logic                    rsp_ready      = 1'b0;
   logic signed [DataW-1:0] rsp_drive_out;
   logic                    rsp_integ_used;
   logic                    csr_we         = 1'b0;
   logic [IdxW-1:0]         csr_index      = '0;
   logic [DataW-1:0]        csr_wdata      = '0;

   logic          no_gaps    = 1'b0;
   int            hold_asked = 0;
   int            hold_taken = 0;
   int            hold_left  = 0;
   pid_scoreboard sb;

   pid_integral_separation_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_error_in   (req_error_in),
      .req_deriv_in   (req_deriv_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_drive_out  (rsp_drive_out),
      .rsp_integ_used (rsp_integ_used),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // Result side: random stalls, plus one long hold counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_asked) begin
         hold_taken <= hold_asked;
         hold_left  <= HoldCycles;
         rsp_ready  <= 1'b0;
      end else if (no_gaps) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 34);
      end
   end

   // Outputs are sampled on the falling edge before the edge that accepts them.
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_word(rsp_drive_out, rsp_integ_used);
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(negedge clock);
         if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $error("no word moved for %0d cycles", WatchdogLimit);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int reg_width(reg_index_type idx);
      case (idx)
         REG_GAIN_PROP, REG_GAIN_INTEG, REG_GAIN_DERIV: return GainW;
         REG_SEP_THR:    return ThrW;
         REG_WINDUP_LIM: return LimW;
         REG_CLAMP_EN:   return 1;
         default:        return DataW;
      endcase
   endfunction

   function automatic logic [DataW-1:0] pick_gain();
      if ($urandom_range(1) == 0) return DataW'(GainW'($urandom));
      return DataW'(int'($urandom_range(0, 1024)) - 512);
   endfunction

   // Mostly in-band errors leaning one way, so the integral runs into the
   // windup limit, with band edges, field extremes and clears mixed in.
   function automatic step_word_type random_word(int thr, int drift);
      step_word_type w;
      int            pick, e;
      pick     = $urandom_range(99);
      w.action = (pick < 4);
      w.der    = ErrW'($urandom);
      if ($urandom_range(4) == 0) w.der = ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
      if (pick < 50) begin
         e = $urandom_range(0, thr);
         if (($urandom_range(3) == 0) == (drift > 0)) e = -e;
      end else if (pick < 65) begin
         case ($urandom_range(3))
            0:       e = thr;
            1:       e = thr + 1;
            2:       e = -thr;
            default: e = -thr - 1;
         endcase
         if (e > 32767) e = 32767;
      end else if (pick < 75) begin
         case ($urandom_range(4))
            0:       e = 32767;
            1:       e = -32768;
            2:       e = 0;
            3:       e = 1;
            default: e = -1;
         endcase
      end else begin
         e = $urandom;
      end
      w.err = ErrW'(e);
      return w;
   endfunction

   task automatic offer(int act, int e, int d);
      logic                   a;
      logic signed [ErrW-1:0] ev, dv;
      a  = act[0];
      ev = ErrW'(e);
      dv = ErrW'(d);
      if (!no_gaps && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= a;
      req_error_in <= ev;
      req_deriv_in <= dv;
      do @(negedge clock); while (req_ready !== 1'b1);
      sb.note_word(a, ev, dv);
      @(posedge clock);
   endtask

   task automatic run_words(int n, int thr);
      step_word_type w;
      int            drift;
      drift = 1;
      for (int i = 0; i < n; i++) begin
         if (i % 64 == 63) drift = -drift;
         w = random_word(thr, drift);
         offer(int'(w.action), int'(w.err), int'(w.der));
      end
   endtask

   // Stop offering and wait until every outstanding word has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all eight registers; unused upper data bits carry noise.
   task automatic program_regs(input logic [DataW-1:0] kp, ki, kd, thr, lim, clamp, up, lo);
      logic [DataW-1:0] vals [8];
      logic [DataW-1:0] data;
      reg_index_type    idx;
      vals = '{kp, ki, kd, thr, lim, clamp, up, lo};
      for (int i = 0; i < 8; i++) begin
         idx  = reg_index_type'(i);
         data = vals[i] | (DataW'($urandom) << reg_width(idx));
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
         @(posedge clock);
         sb.write_register(idx, data);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      int          thr, up, lo, swap;
      logic [31:0] lim;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: band edges, field extremes, clamp and anti-windup both ways.
      program_regs(256, 128, -256, 100, 500, 1, 20000, -20000);
      offer(1, 1234, -1);
      offer(0, 0, 0);
      offer(0, 100, 32767);
      offer(0, 101, -32768);
      offer(0, -100, 0);
      offer(0, -101, 0);
      offer(0, 32767, -32768);
      offer(0, -32768, 32767);
      repeat (6) offer(0, 100, 5);
      offer(0, 50, 0);
      offer(0, -30, 0);
      offer(1, -32768, 32767);
      repeat (6) offer(0, -100, -5);
      offer(0, 50, 0);
      offer(0, -1, 0);
      offer(1, 0, 0);
      settle();

      program_regs(32'hFFFF_8000, 32'h0000_7FFF, 32'hFFFF_8000, 32767, 32'h7FFF_FFFF,
                   0, 0, 0);
      run_words(300, 32767);
      settle();
      program_regs(32'h0000_7FFF, 32'hFFFF_8000, 32'h0000_7FFF, 0, 0, 1,
                   32'h7FFF_FFFF, 32'h8000_0000);
      run_words(200, 0);
      settle();

      // Upper clamp below the lower one, with neither side idling.
      no_gaps <= 1'b1;
      program_regs(pick_gain(), pick_gain(), pick_gain(), 2000, 20000, 1, -1000, 1000);
      run_words(300, 2000);
      settle();
      no_gaps <= 1'b0;

      for (int ph = 0; ph < RandomPhases; ph++) begin
         case ($urandom_range(3))
            0:       thr = 0;
            1:       thr = $urandom_range(1, 300);
            2:       thr = $urandom_range(0, 32767);
            default: thr = 32767;
         endcase
         case ($urandom_range(3))
            0:       lim = 0;
            1:       lim = $urandom_range(0, 3000);
            2:       lim = $urandom_range(0, 32'h7FFF_FFFF);
            default: lim = 32'h7FFF_FFFF;
         endcase
         up   = int'($urandom_range(0, 400000)) - 200000;
         lo   = up - int'($urandom_range(0, 400000));
         swap = $urandom_range(3);
         if (swap == 0) program_regs(pick_gain(), pick_gain(), pick_gain(), thr, lim,
                                     $urandom_range(1), lo, up);
         else program_regs(pick_gain(), pick_gain(), pick_gain(), thr, lim,
                           $urandom_range(1), up, lo);
         // A long result-side hold while words keep coming fills the core.
         if (ph == 1) hold_asked <= hold_asked + 1;
         if (ph == 3) begin
            run_words(100, thr);
            settle();
            run_words(100, thr);
         end else begin
            run_words(200, thr);
         end
         settle();
      end

      repeat (10) @(posedge clock);
      if (sb.pending_outputs.size() != 0) begin
         sb.mismatches++;
         $error("%0d expected result words never arrived", sb.pending_outputs.size());
      end
      $display("Covered %0d words: %0d clears, %0d outside the separation band,",
               sb.words_in, sb.clears, sb.frozen);
      $display("%0d held by anti-windup; integral rails hit %0d high, %0d low.",
               sb.held_back, sb.rail_hi, sb.rail_lo);
      $display("Output saturated %0d times and clamped %0d times.",
               sb.out_sat, sb.clamped);
      if (sb.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
